// ===== rtl/snf_pkg.sv =====
// ----------------------------------------------------------------------------
// snf_pkg
// Shared types and constants for the SPI NOR flash slave.
// ----------------------------------------------------------------------------
package snf_pkg;

    localparam int ADDR_BYTES_W = 24;
    localparam int PTR_W        = 25;
    localparam int SPAN_W       = 26;

    // bus event codes
    localparam logic [1:0] CMD_SELECT  = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_BYTE    = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // opcodes
    localparam logic [7:0] OP_READ         = 8'h03;
    localparam logic [7:0] OP_PROGRAM      = 8'h02;
    localparam logic [7:0] OP_SECTOR_ERASE = 8'h20;
    localparam logic [7:0] OP_BLOCK_ERASE  = 8'hD8;
    localparam logic [7:0] OP_STATUS       = 8'h05;

    // address purpose
    localparam logic [1:0] PURPOSE_NONE    = 2'd0;
    localparam logic [1:0] PURPOSE_ERASE   = 2'd1;
    localparam logic [1:0] PURPOSE_PROGRAM = 2'd2;
    localparam logic [1:0] PURPOSE_READ    = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_ERROR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STICKY_BUSY = 1'd1;

    localparam logic [7:0] BYTE_IDLE   = 8'hFF;
    localparam logic [7:0] STATUS_WIP  = 8'h01;
    localparam logic [7:0] STATUS_NONE = 8'h00;
    localparam logic [1:0] ADDR_LEN    = 2'd3;

    typedef struct packed {
        logic accept;   // latch item, start array read
        logic commit;   // execute item, load result
        logic walk;     // write one erased byte
    } snf_cmd_t;

    typedef struct packed {
        logic out_free;
        logic erase_go;
        logic walk_last;
    } snf_sts_t;

endpackage

// ===== rtl/snf_ctrl.sv =====
// ----------------------------------------------------------------------------
// snf_ctrl
// Sequencer: array sweep, item accept, execute.
// ----------------------------------------------------------------------------
module snf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  snf_pkg::snf_sts_t sts,
    output snf_pkg::snf_cmd_t cmd
);

    localparam logic [1:0] ST_WALK = 2'd0;
    localparam logic [1:0] ST_IDLE = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.accept = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.commit = (state_reg == ST_EXEC) && sts.out_free;
    assign cmd.walk   = (state_reg == ST_WALK);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_WALK:
            begin
                if (sts.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.erase_go ? ST_WALK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WALK;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/snf_datapath.sv =====
// ----------------------------------------------------------------------------
// snf_datapath
// Frame decoder, flash array, erase walker and result register.
// ----------------------------------------------------------------------------
module snf_datapath
#(
    parameter int FLASH_BYTES  = 65536,
    parameter int SECTOR_BYTES = 4096,
    parameter int BLOCK_BYTES  = 65536
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  snf_pkg::snf_cmd_t                  cmd,
    output snf_pkg::snf_sts_t                  sts,
    input  logic [1:0]                         item_command,
    input  logic [7:0]                         item_tx_byte,
    input  logic                               cfg_we,
    input  logic [snf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic                               cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         out_rx_byte,
    output logic                               out_status
);

    localparam int AW     = $clog2(FLASH_BYTES);
    localparam int WALK_W = $clog2(FLASH_BYTES + 1);
    localparam logic [snf_pkg::SPAN_W-1:0] FLASH_SPAN  = snf_pkg::SPAN_W'(FLASH_BYTES);
    localparam logic [snf_pkg::SPAN_W-1:0] SECTOR_SPAN = snf_pkg::SPAN_W'(SECTOR_BYTES);
    localparam logic [snf_pkg::SPAN_W-1:0] BLOCK_SPAN  = snf_pkg::SPAN_W'(BLOCK_BYTES);
    localparam logic [snf_pkg::PTR_W-1:0]  FLASH_PTR   = snf_pkg::PTR_W'(FLASH_BYTES);
    localparam logic [WALK_W-1:0]          FLASH_WALK  = WALK_W'(FLASH_BYTES);
    localparam logic [WALK_W-1:0]          SECTOR_WALK = WALK_W'(SECTOR_BYTES);
    localparam logic [WALK_W-1:0]          BLOCK_WALK  = WALK_W'(BLOCK_BYTES);

    logic [7:0] mem [FLASH_BYTES];
    logic [7:0] rdata_reg;

    logic [1:0] item_cmd_reg;
    logic [7:0] item_tx_reg;

    logic                                  selected_reg, selected_next;
    logic                                  expect_reg, expect_next;
    logic                                  past_reg, past_next;
    logic [7:0]                            opcode_reg, opcode_next;
    logic [snf_pkg::ADDR_BYTES_W-1:0]      ashift_reg, ashift_next;
    logic [1:0]                            abl_reg, abl_next;
    logic [1:0]                            purpose_reg, purpose_next;
    logic [snf_pkg::PTR_W-1:0]             ptr_reg, ptr_next;
    logic                                  in_data_reg, in_data_next;
    logic                                  busy_reg, busy_next;
    logic                                  force_err_reg;
    logic                                  sticky_reg;

    logic [AW-1:0]     walk_addr_reg;
    logic [WALK_W-1:0] walk_left_reg;

    logic                      out_valid_reg;
    logic [7:0]                rx_reg;
    logic                      status_reg;

    logic [7:0]                rx_c;
    logic                      err_c;
    logic                      prog_we;
    logic                      erase_go;
    logic [WALK_W-1:0]         erase_len;
    logic [snf_pkg::SPAN_W-1:0] erase_end;
    logic                      cfg_busy_set;

    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.erase_go  = erase_go;
    assign sts.walk_last = (walk_left_reg == WALK_W'(1));

    assign out_valid   = out_valid_reg;
    assign out_rx_byte = rx_reg;
    assign out_status  = status_reg;

    assign cfg_busy_set = cfg_we && (cfg_index == snf_pkg::CFG_STICKY_BUSY) && cfg_data;

    always_comb
    begin
        selected_next = selected_reg;
        expect_next   = expect_reg;
        past_next     = past_reg;
        opcode_next   = opcode_reg;
        ashift_next   = ashift_reg;
        abl_next      = abl_reg;
        purpose_next  = purpose_reg;
        ptr_next      = ptr_reg;
        in_data_next  = in_data_reg;
        busy_next     = busy_reg;
        rx_c          = snf_pkg::BYTE_IDLE;
        err_c         = 1'b0;
        prog_we       = 1'b0;
        erase_go      = 1'b0;
        erase_len     = SECTOR_WALK;
        erase_end     = '0;

        if (force_err_reg || item_cmd_reg == snf_pkg::CMD_UNUSED)
        begin
            err_c = 1'b1;
        end
        else if (item_cmd_reg == snf_pkg::CMD_SELECT)
        begin
            selected_next = 1'b1;
            expect_next   = 1'b1;
            past_next     = 1'b0;
            in_data_next  = 1'b0;
        end
        else if (item_cmd_reg == snf_pkg::CMD_RELEASE)
        begin
            selected_next = 1'b0;
            expect_next   = 1'b0;
            past_next     = 1'b0;
            abl_next      = 2'd0;
            purpose_next  = snf_pkg::PURPOSE_NONE;
            in_data_next  = 1'b0;
        end
        else if (!selected_reg)
        begin
            err_c = 1'b1;
        end
        else
        begin
            if (expect_reg)
            begin
                opcode_next  = item_tx_reg;
                ashift_next  = '0;
                abl_next     = 2'd0;
                purpose_next = snf_pkg::PURPOSE_NONE;
                in_data_next = 1'b0;
                ptr_next     = '0;
                expect_next  = 1'b0;
                case (item_tx_reg)
                    snf_pkg::OP_PROGRAM:
                    begin
                        abl_next     = snf_pkg::ADDR_LEN;
                        purpose_next = snf_pkg::PURPOSE_PROGRAM;
                        busy_next    = 1'b1;
                    end
                    snf_pkg::OP_READ:
                    begin
                        abl_next     = snf_pkg::ADDR_LEN;
                        purpose_next = snf_pkg::PURPOSE_READ;
                    end
                    snf_pkg::OP_SECTOR_ERASE, snf_pkg::OP_BLOCK_ERASE:
                    begin
                        abl_next     = snf_pkg::ADDR_LEN;
                        purpose_next = snf_pkg::PURPOSE_ERASE;
                        busy_next    = 1'b1;
                    end
                    default:
                    begin
                        abl_next = 2'd0;
                    end
                endcase
            end
            else if (abl_reg != 2'd0)
            begin
                ashift_next = {ashift_reg[15:0], item_tx_reg};
                abl_next    = abl_reg - 2'd1;
                if (abl_reg == 2'd1)
                begin
                    ptr_next     = {1'b0, ashift_next};
                    purpose_next = snf_pkg::PURPOSE_NONE;
                    if (purpose_reg == snf_pkg::PURPOSE_ERASE)
                    begin
                        if (opcode_reg == snf_pkg::OP_BLOCK_ERASE)
                        begin
                            erase_end = {2'b00, ashift_next} + BLOCK_SPAN;
                            erase_len = BLOCK_WALK;
                            erase_go  = (erase_end <= FLASH_SPAN);
                            err_c     = !erase_go;
                        end
                        else if (opcode_reg == snf_pkg::OP_SECTOR_ERASE)
                        begin
                            erase_end = {2'b00, ashift_next} + SECTOR_SPAN;
                            erase_len = SECTOR_WALK;
                            erase_go  = (erase_end <= FLASH_SPAN);
                            err_c     = !erase_go;
                        end
                    end
                    else if (purpose_reg == snf_pkg::PURPOSE_PROGRAM ||
                             purpose_reg == snf_pkg::PURPOSE_READ)
                    begin
                        in_data_next = 1'b1;
                    end
                end
            end
            else if (in_data_reg && ptr_reg < FLASH_PTR)
            begin
                if (opcode_reg == snf_pkg::OP_READ)
                begin
                    rx_c     = rdata_reg;
                    ptr_next = ptr_reg + snf_pkg::PTR_W'(1);
                end
                else if (opcode_reg == snf_pkg::OP_PROGRAM)
                begin
                    prog_we  = 1'b1;
                    ptr_next = ptr_reg + snf_pkg::PTR_W'(1);
                end
            end

            if (!err_c)
            begin
                if (opcode_next == snf_pkg::OP_STATUS && past_reg)
                begin
                    if (sticky_reg)
                    begin
                        rx_c = snf_pkg::STATUS_WIP;
                    end
                    else if (busy_next)
                    begin
                        rx_c      = snf_pkg::STATUS_WIP;
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        rx_c = snf_pkg::STATUS_NONE;
                    end
                end
                past_next = 1'b1;
            end
        end
    end

    // flash array: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.walk)
        begin
            mem[walk_addr_reg] <= snf_pkg::BYTE_IDLE;
        end
        else if (cmd.commit && prog_we)
        begin
            mem[ptr_reg[AW-1:0]] <= rdata_reg & item_tx_reg;
        end
        if (cmd.accept)
        begin
            rdata_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_cmd_reg <= item_command;
            item_tx_reg  <= item_tx_byte;
        end
        if (cmd.commit)
        begin
            rx_reg     <= rx_c;
            status_reg <= err_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            selected_reg  <= 1'b0;
            expect_reg    <= 1'b0;
            past_reg      <= 1'b0;
            opcode_reg    <= 8'h00;
            ashift_reg    <= '0;
            abl_reg       <= 2'd0;
            purpose_reg   <= snf_pkg::PURPOSE_NONE;
            ptr_reg       <= '0;
            in_data_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            force_err_reg <= 1'b0;
            sticky_reg    <= 1'b0;
            walk_addr_reg <= '0;
            walk_left_reg <= FLASH_WALK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                selected_reg <= selected_next;
                expect_reg   <= expect_next;
                past_reg     <= past_next;
                opcode_reg   <= opcode_next;
                ashift_reg   <= ashift_next;
                abl_reg      <= abl_next;
                purpose_reg  <= purpose_next;
                ptr_reg      <= ptr_next;
                in_data_reg  <= in_data_next;
                busy_reg     <= busy_next || cfg_busy_set;
            end
            else if (cfg_busy_set)
            begin
                busy_reg <= 1'b1;
            end

            if (cfg_we && cfg_index == snf_pkg::CFG_FORCE_ERROR)
            begin
                force_err_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == snf_pkg::CFG_STICKY_BUSY)
            begin
                sticky_reg <= cfg_data;
            end

            if (cmd.commit && erase_go)
            begin
                walk_addr_reg <= ashift_next[AW-1:0];
                walk_left_reg <= erase_len;
            end
            else if (cmd.walk)
            begin
                walk_addr_reg <= walk_addr_reg + AW'(1);
                walk_left_reg <= walk_left_reg - WALK_W'(1);
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/spi_nor_flash_slave.sv =====
// ----------------------------------------------------------------------------
// spi_nor_flash_slave
// Byte-level slave side of a SPI NOR flash with read, program, erase, RDSR.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: tx_byte; tuser: command
//  m_*       out  m_tvalid/m_tready  tdata: rx_byte; tuser: status
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each item is accepted with an array read, then executed.
// An accepted erase stalls input while SECTOR_BYTES or BLOCK_BYTES bytes
// are written to 0xFF, one array byte written per cycle.
// After reset all FLASH_BYTES array bytes are swept to 0xFF; no item
// is accepted meanwhile, config writes are.
// A result waiting on m_tready holds the next item in its execute cycle.
// ----------------------------------------------------------------------------
module spi_nor_flash_slave
#(
    parameter int FLASH_BYTES  = 65536,
    parameter int SECTOR_BYTES = 4096,
    parameter int BLOCK_BYTES  = 65536
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // [7:0] tx_byte
    input  logic [1:0]                    s_tuser,    // [1:0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,    // [7:0] rx_byte
    output logic [0:0]                    m_tuser,    // [0] status
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [snf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                          cfg_data
);

    snf_pkg::snf_cmd_t cmd;
    snf_pkg::snf_sts_t sts;
    logic              out_status;

    assign cfg_ready  = 1'b1;
    assign m_tuser[0] = out_status;

    snf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    snf_datapath
    #(
        .FLASH_BYTES  (FLASH_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .BLOCK_BYTES  (BLOCK_BYTES)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .item_command (s_tuser),
        .item_tx_byte (s_tdata),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_rx_byte  (m_tdata),
        .out_status   (out_status)
    );

endmodule
